/* design/skltc_pkg.sv */
package skltc_pkg;

   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_LIST   = 3'd2,
      ACT_CLEAR  = 3'd3,
      ACT_APPEND = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_MISSING = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        ins_head;
      logic        ins_mid;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

endpackage

/* design/skltc_cell.sv */
module skltc_cell #(
   parameter int KEY_BITS = 16,
   parameter int CNT_BITS = 5,
   parameter int INDEX    = 0
) (
   input  logic                       clock,
   input  skltc_pkg::cell_ctrl_type   ctrl,
   input  logic signed [KEY_BITS-1:0] op_key,
   input  logic [CNT_BITS-1:0]        count,
   input  logic signed [KEY_BITS-1:0] left_key,
   input  logic signed [KEY_BITS-1:0] right_key,
   input  logic signed [KEY_BITS-1:0] wrap_key,
   input  logic                       ins_prior_i,
   input  logic                       del_prior_i,
   output logic                       ins_prior_o,
   output logic                       del_prior_o,
   output logic signed [KEY_BITS-1:0] key_o,
   output logic                       lt_o
);

   localparam logic [CNT_BITS-1:0] IDX      = CNT_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] IDX_NEXT = CNT_BITS'(INDEX + 1);
   localparam logic                IS_HEAD  = (INDEX == 0);

   logic signed [KEY_BITS-1:0] key_ff;
   logic signed [KEY_BITS-1:0] key_in;
   logic occ;
   logic at_count;
   logic lt;
   logic hit;
   logic match;

   assign occ      = (count > IDX);
   assign at_count = (count == IDX);
   assign lt       = (key_ff < op_key);

   // first hit marks the insert slot; everything after it moves right
   assign hit = at_count
              | (ctrl.ins_mid & !IS_HEAD & occ & !lt)
              | (ctrl.ins_head & IS_HEAD);
   assign match = occ & (key_ff == op_key);

   assign ins_prior_o = ins_prior_i | hit;
   assign del_prior_o = del_prior_i | match;
   assign key_o       = key_ff;
   assign lt_o        = lt;

   always_comb begin
      case (ctrl.op)
         skltc_pkg::CELL_INSERT: begin
            if (ins_prior_i) begin
               key_in = left_key;
            end else if (hit) begin
               key_in = op_key;
            end else begin
               key_in = key_ff;
            end
         end
         skltc_pkg::CELL_DELETE: begin
            key_in = (del_prior_i | match) ? right_key : key_ff;
         end
         skltc_pkg::CELL_ROTATE: begin
            // the last occupied cell takes the head back
            key_in = (count == IDX_NEXT) ? wrap_key : right_key;
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

/* design/sorted_key_list_table_core.sv */
// Channel   Ports                                   Direction  Handshake
// request   req_action, req_item_key                in         start high, busy low
// response  rsp_entry_key, rsp_status,              out        rsp_strobe, one cycle
//           rsp_entry_count, rsp_last_result
//
// For insert, append, delete, clear and unused codes the cell chain updates in
// the accepting cycle and the response beat follows on the next.
// A list gives one response beat per held entry (one if empty); the chain rotates one
// place per cycle through cell 0, and busy stays high until the last beat.
// Reset clears the entry count and the control state; cell keys are not reset.
// The receiver cannot stall: each response beat stands for exactly one cycle.
module sorted_key_list_table_core #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [2:0]                       req_action,
   input  logic signed [KEY_BITS-1:0]       req_item_key,
   output logic                             rsp_strobe,
   output logic signed [KEY_BITS-1:0]       rsp_entry_key,
   output logic [1:0]                       rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_entry_count,
   output logic                             rsp_last_result
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0] ONE        = CNT_BITS'(1);

   skltc_pkg::state_type     state_ff, state_in;
   skltc_pkg::cell_ctrl_type ctrl;
   skltc_pkg::action_type    action;

   logic [CNT_BITS-1:0]        count_ff, count_in;
   logic [CNT_BITS-1:0]        list_idx_ff, list_idx_in;
   logic                       strobe_ff, strobe_in;
   logic signed [KEY_BITS-1:0] entry_key_ff, entry_key_in;
   logic [1:0]                 status_ff, status_in;
   logic [CNT_BITS-1:0]        entry_count_ff, entry_count_in;
   logic                       last_ff, last_in;

   logic signed [KEY_BITS-1:0] key_vec [DEPTH];
   logic [DEPTH-1:0]           lt_vec;
   logic [DEPTH-1:0]           tail_sel;
   logic [DEPTH:0]             ins_chain;
   logic [DEPTH:0]             del_chain;
   logic                       tail_lt;
   logic                       head_gt;

   assign ins_chain[0] = 1'b0;
   assign del_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [KEY_BITS-1:0] left_key;
      logic signed [KEY_BITS-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_key = req_item_key;
      end else begin : g_mid
         assign left_key = key_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_key = key_vec[i];
      end else begin : g_inner
         assign right_key = key_vec[i+1];
      end

      assign tail_sel[i] = (count_ff == CNT_BITS'(i + 1));

      skltc_cell #(
         .KEY_BITS (KEY_BITS),
         .CNT_BITS (CNT_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .op_key      (req_item_key),
         .count       (count_ff),
         .left_key    (left_key),
         .right_key   (right_key),
         .wrap_key    (key_vec[0]),
         .ins_prior_i (ins_chain[i]),
         .del_prior_i (del_chain[i]),
         .ins_prior_o (ins_chain[i+1]),
         .del_prior_o (del_chain[i+1]),
         .key_o       (key_vec[i]),
         .lt_o        (lt_vec[i])
      );
   end

   assign tail_lt = |(lt_vec & tail_sel);
   assign head_gt = (key_vec[0] > req_item_key);
   assign action  = skltc_pkg::action_type'(req_action);

   assign busy            = (state_ff == skltc_pkg::ST_LIST);
   assign rsp_strobe      = strobe_ff;
   assign rsp_entry_key   = entry_key_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_last_result = last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      list_idx_in   = list_idx_ff;
      strobe_in     = 1'b0;
      entry_key_in  = entry_key_ff;
      status_in     = status_ff;
      last_in       = last_ff;
      ctrl.op       = skltc_pkg::CELL_HOLD;
      ctrl.ins_head = 1'b0;
      ctrl.ins_mid  = 1'b0;

      unique case (state_ff)
         skltc_pkg::ST_IDLE: begin
            if (start) begin
               strobe_in    = 1'b1;
               last_in      = 1'b1;
               entry_key_in = req_item_key;
               status_in    = skltc_pkg::STAT_OK;
               unique case (action) inside
                  skltc_pkg::ACT_INSERT, skltc_pkg::ACT_APPEND: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = skltc_pkg::STAT_FULL;
                     end else begin
                        ctrl.op = skltc_pkg::CELL_INSERT;
                        if (action == skltc_pkg::ACT_INSERT && count_ff != '0 && !tail_lt) begin
                           ctrl.ins_head = head_gt;
                           ctrl.ins_mid  = !head_gt;
                        end
                        count_in = count_ff + ONE;
                     end
                  end
                  skltc_pkg::ACT_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = skltc_pkg::STAT_EMPTY;
                     end else begin
                        ctrl.op = skltc_pkg::CELL_DELETE;
                        if (del_chain[DEPTH]) begin
                           count_in = count_ff - ONE;
                        end else begin
                           status_in = skltc_pkg::STAT_MISSING;
                        end
                     end
                  end
                  skltc_pkg::ACT_LIST: begin
                     if (count_ff == '0) begin
                        entry_key_in = '0;
                        status_in    = skltc_pkg::STAT_EMPTY;
                     end else begin
                        // emit the head now, rotate the rest through cell 0
                        entry_key_in = key_vec[0];
                        ctrl.op      = skltc_pkg::CELL_ROTATE;
                        if (count_ff != ONE) begin
                           last_in     = 1'b0;
                           list_idx_in = ONE;
                           state_in    = skltc_pkg::ST_LIST;
                        end
                     end
                  end
                  skltc_pkg::ACT_CLEAR: begin
                     entry_key_in = '0;
                     count_in     = '0;
                  end
                  default: begin
                     entry_key_in = '0;
                  end
               endcase
            end
         end
         skltc_pkg::ST_LIST: begin
            strobe_in    = 1'b1;
            entry_key_in = key_vec[0];
            status_in    = skltc_pkg::STAT_OK;
            ctrl.op      = skltc_pkg::CELL_ROTATE;
            last_in      = (list_idx_ff == count_ff - ONE);
            if (last_in) begin
               state_in = skltc_pkg::ST_IDLE;
            end else begin
               list_idx_in = list_idx_ff + ONE;
            end
         end
         default: begin
            state_in = skltc_pkg::ST_IDLE;
         end
      endcase

      entry_count_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= skltc_pkg::ST_IDLE;
         count_ff    <= '0;
         list_idx_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         list_idx_ff <= list_idx_in;
         strobe_ff   <= strobe_in;
      end
   end

   // hold response payload between beats
   always_ff @(posedge clock) begin
      entry_key_ff   <= entry_key_in;
      status_ff      <= status_in;
      entry_count_ff <= entry_count_in;
      last_ff        <= last_in;
   end

endmodule
